FILE: design/rgba_pixel_compositor_defines.svh
// Assertion macros for the RGBA pixel compositor checker.
// Needs clk and arst_n in the scope where a macro is used.
`ifndef RGBA_PIXEL_COMPOSITOR_DEFINES_SVH
`define RGBA_PIXEL_COMPOSITOR_DEFINES_SVH

// Same-cycle implication, off while reset is asserted.
`define RPC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, off while reset is asserted.
`define RPC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/rpc_pkg.sv
// Shared types and constants of the RGBA pixel compositor.
// No dependencies; used by the compositor, skid, front and divider modules.
package rpc_pkg;

	localparam int unsigned CH_W     = 8;
	localparam int unsigned NUM_CH   = 3;
	localparam int unsigned PROD_W   = 2 * CH_W;
	localparam int unsigned NUM_W    = PROD_W + CH_W + 1;
	localparam int unsigned ALPHA_W  = PROD_W + 1;
	localparam int unsigned RECIP_W  = CH_W + 1;
	localparam int unsigned AMUL_W   = ALPHA_W + RECIP_W;
	localparam int unsigned DSH_PAD  = NUM_W - PROD_W - CH_W + 1;

	localparam logic [1:0] OP_COPY    = 2'd0;
	localparam logic [1:0] OP_BLEND   = 2'd1;
	localparam logic [1:0] OP_FLATTEN = 2'd2;
	localparam logic [1:0] OP_NONE    = 2'd3;

	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_BG_RED   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BG_GREEN = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BG_BLUE  = 2'd2;

	localparam int unsigned CH_RED   = 0;
	localparam int unsigned CH_GREEN = 1;
	localparam int unsigned CH_BLUE  = 2;

	localparam logic [CH_W-1:0]    CH_MAX     = 8'd255;
	localparam logic [PROD_W-1:0]  FLAT_BIAS  = 16'd128;
	localparam logic [ALPHA_W-1:0] ALPHA_BIAS = 17'd127;
	localparam logic [ALPHA_W-1:0] ALPHA_DIV  = 17'd255;
	localparam logic [RECIP_W-1:0] RECIP_255  = 9'd257;

	typedef logic [NUM_CH-1:0][CH_W-1:0]   rgb_t;
	typedef logic [NUM_CH-1:0][PROD_W-1:0] prod3_t;
	typedef logic [NUM_CH-1:0][NUM_W-1:0]  num_t;

	typedef struct packed {
		rgb_t            rgb;
		logic [CH_W-1:0] alpha;
	} pix_t;

	typedef struct packed {
		logic [1:0] op;
		pix_t       src;
		pix_t       dst;
		logic       last;
	} in_word_t;

	// Result known before the divider, plus whether the divider supplies the colors.
	typedef struct packed {
		pix_t res;
		logic use_div;
		logic last;
	} side_t;

	typedef struct packed {
		num_t              num;
		logic [PROD_W-1:0] denom;
		side_t             side;
	} div_in_t;

endpackage

FILE: design/rgba_pixel_compositor.sv
// RGBA pixel compositor: copy, non-premultiplied source-over blend, flatten onto background.
// Path of a word: the skid register, the front stages and then the divider stages.
// Throughput: one pixel per cycle; the pipeline holds when out_stall holds a result,
// and a skid register takes the word that arrives in that cycle.
// Reset clears the stage valid bits, the skid register and the background colour.
module rgba_pixel_compositor (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    op,
	input  logic [7:0]                    src_red,
	input  logic [7:0]                    src_green,
	input  logic [7:0]                    src_blue,
	input  logic [7:0]                    src_alpha,
	input  logic [7:0]                    dst_red,
	input  logic [7:0]                    dst_green,
	input  logic [7:0]                    dst_blue,
	input  logic [7:0]                    dst_alpha,
	input  logic                          last_in_frame,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [7:0]                    out_red,
	output logic [7:0]                    out_green,
	output logic [7:0]                    out_blue,
	output logic [7:0]                    out_alpha,
	output logic                          frame_end,
	input  logic                          cfg_write,
	input  logic [rpc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]                    cfg_data
);

	rpc_pkg::rgb_t     bg_q;
	rpc_pkg::in_word_t in_word;
	rpc_pkg::in_word_t skid_word;
	logic              skid_valid;
	rpc_pkg::div_in_t  div_word;
	logic              div_valid;
	rpc_pkg::pix_t     res;
	logic              en;

	// Every stage moves together unless a finished word is held at the output.
	assign en = !(out_valid && out_stall);

	always_comb begin
		in_word.op                           = op;
		in_word.src.rgb[rpc_pkg::CH_RED]     = src_red;
		in_word.src.rgb[rpc_pkg::CH_GREEN]   = src_green;
		in_word.src.rgb[rpc_pkg::CH_BLUE]    = src_blue;
		in_word.src.alpha                    = src_alpha;
		in_word.dst.rgb[rpc_pkg::CH_RED]     = dst_red;
		in_word.dst.rgb[rpc_pkg::CH_GREEN]   = dst_green;
		in_word.dst.rgb[rpc_pkg::CH_BLUE]    = dst_blue;
		in_word.dst.alpha                    = dst_alpha;
		in_word.last                         = last_in_frame;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bg_q <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				rpc_pkg::CFG_BG_RED:   bg_q[rpc_pkg::CH_RED]   <= cfg_data;
				rpc_pkg::CFG_BG_GREEN: bg_q[rpc_pkg::CH_GREEN] <= cfg_data;
				rpc_pkg::CFG_BG_BLUE:  bg_q[rpc_pkg::CH_BLUE]  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	rpc_skid u_skid (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.din        (in_word),
		.dout_valid (skid_valid),
		.dout       (skid_word)
	);

	rpc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.word_valid (skid_valid),
		.word       (skid_word),
		.bg         (bg_q),
		.div_valid  (div_valid),
		.div_word   (div_word)
	);

	rpc_div_pipe u_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.din_valid  (div_valid),
		.din        (div_word),
		.dout_valid (out_valid),
		.dout       (res),
		.dout_last  (frame_end)
	);

	assign out_red   = res.rgb[rpc_pkg::CH_RED];
	assign out_green = res.rgb[rpc_pkg::CH_GREEN];
	assign out_blue  = res.rgb[rpc_pkg::CH_BLUE];
	assign out_alpha = res.alpha;

endmodule

FILE: design/rpc_skid.sv
// Input skid register of the RGBA pixel compositor.
// Depends on rpc_pkg for the input word type.
module rpc_skid (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	output logic              in_stall,
	input  rpc_pkg::in_word_t din,
	output logic              dout_valid,
	output rpc_pkg::in_word_t dout
);

	logic              full_q;
	rpc_pkg::in_word_t buf_q;

	assign in_stall   = full_q;
	assign dout_valid = full_q | in_valid;
	assign dout       = full_q ? buf_q : din;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
		end else if (en) begin
			full_q <= 1'b0;
		end else if (in_valid && !full_q) begin
			full_q <= 1'b1;
		end
	end

	// A word arriving while the pipeline holds is parked here.
	always_ff @(posedge clk) begin
		if (!en && in_valid && !full_q) begin
			buf_q <= din;
		end
	end

endmodule

FILE: design/rpc_front.sv
// Front stages of the RGBA pixel compositor: weights, numerators, flatten and alpha.
// Depends on rpc_pkg; feeds rpc_div_pipe.
module rpc_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              word_valid,
	input  rpc_pkg::in_word_t word,
	input  rpc_pkg::rgb_t     bg,
	output logic              div_valid,
	output rpc_pkg::div_in_t  div_word
);

	rpc_pkg::in_word_t word_s1;
	logic              vld_s1;

	rpc_pkg::in_word_t           word_s2;
	logic [rpc_pkg::PROD_W-1:0]  ws_s2;
	logic [rpc_pkg::PROD_W-1:0]  wd_s2;
	rpc_pkg::prod3_t             sa_s2;
	rpc_pkg::prod3_t             bi_s2;
	logic                        vld_s2;

	rpc_pkg::num_t               num_s3;
	logic [rpc_pkg::PROD_W-1:0]  den_s3;
	rpc_pkg::side_t              side_s3;
	logic                        vld_s3;

	rpc_pkg::num_t               num_s4;
	logic [rpc_pkg::PROD_W-1:0]  den_s4;
	rpc_pkg::side_t              side_s4;
	logic [rpc_pkg::ALPHA_W-1:0] xa_s4;
	logic [rpc_pkg::RECIP_W-1:0] q0_s4;
	logic                        vld_s4;

	logic [rpc_pkg::CH_W-1:0]    inv1;
	logic [rpc_pkg::PROD_W-1:0]  ws1;
	logic [rpc_pkg::PROD_W-1:0]  wd1;
	rpc_pkg::prod3_t             sa1;
	rpc_pkg::prod3_t             bi1;

	rpc_pkg::num_t               num2;
	logic [rpc_pkg::PROD_W-1:0]  den2;
	rpc_pkg::rgb_t               fl2;
	rpc_pkg::side_t              side2;

	logic [rpc_pkg::ALPHA_W-1:0] xa3;
	logic [rpc_pkg::AMUL_W-1:0]  am3;

	logic [rpc_pkg::ALPHA_W-1:0] qm4;
	logic [rpc_pkg::ALPHA_W-1:0] rr4;
	logic [rpc_pkg::RECIP_W-1:0] aq4;

	// Stage 1: source and destination weights, flatten products.
	always_comb begin
		inv1 = rpc_pkg::CH_MAX - word_s1.src.alpha;
		ws1  = {word_s1.src.alpha, {rpc_pkg::CH_W{1'b0}}}
			- {{rpc_pkg::CH_W{1'b0}}, word_s1.src.alpha};
		wd1  = word_s1.dst.alpha * inv1;
		for (int c = 0; c < rpc_pkg::NUM_CH; c++) begin
			sa1[c] = word_s1.src.rgb[c] * word_s1.src.alpha;
			bi1[c] = bg[c] * inv1;
		end
	end

	// Stage 2: blend numerators and denominator, flatten rounding, bypass results.
	always_comb begin
		logic [rpc_pkg::NUM_W-2:0]  pa;
		logic [rpc_pkg::NUM_W-2:0]  pb;
		logic [rpc_pkg::PROD_W:0]   dsum;
		logic [rpc_pkg::PROD_W:0]   fx;
		logic [rpc_pkg::PROD_W-1:0] ft;
		logic [rpc_pkg::PROD_W:0]   fr;
		pa   = '0;
		pb   = '0;
		fx   = '0;
		ft   = '0;
		fr   = '0;
		for (int c = 0; c < rpc_pkg::NUM_CH; c++) begin
			pa      = ws_s2 * word_s2.src.rgb[c];
			pb      = wd_s2 * word_s2.dst.rgb[c];
			num2[c] = {1'b0, pa} + {1'b0, pb};
			// Rounded divide by 255: t = x + 128, then (t + t/256) / 256.
			fx      = {1'b0, sa_s2[c]} + {1'b0, bi_s2[c]};
			ft      = fx[rpc_pkg::PROD_W-1:0] + rpc_pkg::FLAT_BIAS;
			fr      = {1'b0, ft}
				+ {{(rpc_pkg::CH_W+1){1'b0}}, ft[rpc_pkg::PROD_W-1:rpc_pkg::CH_W]};
			fl2[c]  = fr[rpc_pkg::PROD_W-1:rpc_pkg::CH_W];
		end
		dsum = {1'b0, ws_s2} + {1'b0, wd_s2};
		den2 = dsum[rpc_pkg::PROD_W-1:0];

		side2.last    = word_s2.last;
		side2.use_div = 1'b0;
		side2.res     = word_s2.dst;
		case (word_s2.op)
			rpc_pkg::OP_COPY: begin
				side2.res = word_s2.src;
			end
			rpc_pkg::OP_BLEND: begin
				if (word_s2.src.alpha == rpc_pkg::CH_MAX) begin
					side2.res.rgb   = word_s2.src.rgb;
					side2.res.alpha = rpc_pkg::CH_MAX;
				end else if (word_s2.src.alpha != '0) begin
					side2.use_div = 1'b1;
				end
			end
			rpc_pkg::OP_FLATTEN: begin
				side2.res.rgb   = fl2;
				side2.res.alpha = rpc_pkg::CH_MAX;
			end
			rpc_pkg::OP_NONE: begin
			end
			default: begin
			end
		endcase
	end

	// Stage 3: estimate of (denom + 127) / 255 by the reciprocal 257 / 65536.
	always_comb begin
		xa3 = {1'b0, den_s3} + rpc_pkg::ALPHA_BIAS;
		am3 = xa3 * rpc_pkg::RECIP_255;
	end

	// Stage 4 output: the estimate is low by at most one, so one compare corrects it.
	always_comb begin
		qm4 = {q0_s4, {rpc_pkg::CH_W{1'b0}}} - {{rpc_pkg::CH_W{1'b0}}, q0_s4};
		rr4 = xa_s4 - qm4;
		aq4 = (rr4 >= rpc_pkg::ALPHA_DIV) ? q0_s4 + 1'b1 : q0_s4;

		div_word.num   = num_s4;
		div_word.denom = den_s4;
		div_word.side  = side_s4;
		if (side_s4.use_div) begin
			div_word.side.res.alpha = aq4[rpc_pkg::CH_W-1:0];
		end
	end

	assign div_valid = vld_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= word_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			word_s1 <= word;

			word_s2 <= word_s1;
			ws_s2   <= ws1;
			wd_s2   <= wd1;
			sa_s2   <= sa1;
			bi_s2   <= bi1;

			num_s3  <= num2;
			den_s3  <= den2;
			side_s3 <= side2;

			num_s4  <= num_s3;
			den_s4  <= den_s3;
			side_s4 <= side_s3;
			xa_s4   <= xa3;
			q0_s4   <= am3[rpc_pkg::AMUL_W-2:rpc_pkg::PROD_W];
		end
	end

endmodule

FILE: design/rpc_div_pipe.sv
// Pipelined restoring divider of the RGBA pixel compositor, one quotient bit per stage.
// Depends on rpc_pkg; takes words from rpc_front and picks the final pixel.
module rpc_div_pipe (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             din_valid,
	input  rpc_pkg::div_in_t din,
	output logic             dout_valid,
	output rpc_pkg::pix_t    dout,
	output logic             dout_last
);

	localparam int unsigned Steps = rpc_pkg::CH_W;

	rpc_pkg::num_t              rem_s  [Steps];
	rpc_pkg::rgb_t              quo_s  [Steps];
	logic [rpc_pkg::PROD_W-1:0] den_s  [Steps];
	rpc_pkg::side_t             side_s [Steps];
	logic                       vld_s  [Steps];

	for (genvar k = 0; k < Steps; k++) begin : g_stage
		rpc_pkg::num_t              rem_in;
		rpc_pkg::rgb_t              quo_in;
		logic [rpc_pkg::PROD_W-1:0] den_in;
		rpc_pkg::side_t             side_in;
		logic                       vld_in;
		logic [rpc_pkg::NUM_W-1:0]  dsh;
		rpc_pkg::num_t              rem_nx;
		rpc_pkg::rgb_t              quo_nx;

		if (k == 0) begin : g_head
			assign rem_in  = din.num;
			assign quo_in  = '0;
			assign den_in  = din.denom;
			assign side_in = din.side;
			assign vld_in  = din_valid;
		end else begin : g_body
			assign rem_in  = rem_s[k-1];
			assign quo_in  = quo_s[k-1];
			assign den_in  = den_s[k-1];
			assign side_in = side_s[k-1];
			assign vld_in  = vld_s[k-1];
		end

		// The remainder shifts left each step, so the divisor stays at one fixed offset.
		assign dsh = {{rpc_pkg::DSH_PAD{1'b0}}, den_in, {(rpc_pkg::CH_W-1){1'b0}}};

		always_comb begin
			logic [rpc_pkg::NUM_W-1:0] diff;
			diff = '0;
			for (int c = 0; c < rpc_pkg::NUM_CH; c++) begin
				if (rem_in[c] >= dsh) begin
					diff      = rem_in[c] - dsh;
					quo_nx[c] = {quo_in[c][rpc_pkg::CH_W-2:0], 1'b1};
				end else begin
					diff      = rem_in[c];
					quo_nx[c] = {quo_in[c][rpc_pkg::CH_W-2:0], 1'b0};
				end
				rem_nx[c] = {diff[rpc_pkg::NUM_W-2:0], 1'b0};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= rem_nx;
				quo_s[k]  <= quo_nx;
				den_s[k]  <= den_in;
				side_s[k] <= side_in;
			end
		end
	end

	always_comb begin
		dout = side_s[Steps-1].res;
		if (side_s[Steps-1].use_div) begin
			dout.rgb = quo_s[Steps-1];
		end
	end

	assign dout_last  = side_s[Steps-1].last;
	assign dout_valid = vld_s[Steps-1];

endmodule

FILE: design/rpc_chk.sv
// Port-level checker of the RGBA pixel compositor, bound to the top level.
// Depends on rgba_pixel_compositor_defines.svh for the assertion macros.
`include "rgba_pixel_compositor_defines.svh"

module rpc_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] out_red,
	input logic [7:0] out_green,
	input logic [7:0] out_blue,
	input logic [7:0] out_alpha,
	input logic       frame_end
);

	logic [32:0] out_word;

	assign out_word = {out_red, out_green, out_blue, out_alpha, frame_end};

	`RPC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "output word dropped")

	`RPC_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_word), "output word changed")

	// The skid register drains whenever the output side moves.
	`RPC_ASSERT_NEXT(a_in_free, !(out_valid && out_stall), !in_stall, "input held without cause")

	// Input back-pressure only starts from a held output word.
	`RPC_ASSERT_NOW(a_stall_cause, $rose(in_stall), $past(out_valid && out_stall), "stray input stall")

endmodule

bind rgba_pixel_compositor rpc_chk u_rpc_chk (.*);

FILE: test/tb_top.sv
`timescale 1ns / 100ps
// Testbench of rgba_pixel_compositor: directed and random pixel words, with scoreboard.
// Depends on rpc_pkg and the rgba_pixel_compositor RTL only.

typedef struct packed {
	logic [1:0]      op;
	logic [3:0][7:0] src;
	logic [3:0][7:0] dst;
	logic            last;
} pixel_in_t;

typedef struct packed {
	logic [3:0][7:0] pix;
	logic            frame_end;
} pixel_out_t;

class pixel_scoreboard;
	pixel_out_t      expected_pixels [$];
	logic [2:0][7:0] background;
	int              errors;
	string           chan_name [4];

	function new();
		background = '0;
		errors = 0;
		chan_name = '{"out_red", "out_green", "out_blue", "out_alpha"};
	endfunction

	// Channel 0 is red, 3 is alpha, for both pixels of the word.
	function pixel_out_t composite(pixel_in_t p);
		pixel_out_t  r;
		int unsigned src_a;
		int unsigned dst_a;
		int unsigned inv;
		int unsigned denom;
		int unsigned num;
		int unsigned x;
		int unsigned t;
		src_a = 32'(p.src[3]);
		dst_a = 32'(p.dst[3]);
		inv = 255 - src_a;
		r.pix = p.dst;
		r.frame_end = p.last;
		case (p.op)
			rpc_pkg::OP_COPY: begin
				r.pix = p.src;
			end
			rpc_pkg::OP_BLEND: begin
				if (src_a == 255) begin
					r.pix = p.src;
					r.pix[3] = 8'd255;
				end else if (src_a != 0) begin
					denom = 255 * src_a + dst_a * inv;
					for (int c = 0; c < 3; c++) begin
						num = 255 * src_a * 32'(p.src[c]) + dst_a * inv * 32'(p.dst[c]);
						r.pix[c] = 8'(num / denom);
					end
					r.pix[3] = 8'((denom + 127) / 255);
				end
			end
			rpc_pkg::OP_FLATTEN: begin
				for (int c = 0; c < 3; c++) begin
					x = 32'(p.src[c]) * src_a + 32'(background[c]) * inv;
					t = (x + 128) & 32'hFFFF;
					r.pix[c] = 8'((t + (t >> 8)) >> 8);
				end
				r.pix[3] = 8'd255;
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	function void note_input(pixel_in_t p);
		expected_pixels.push_back(composite(p));
	endfunction

	function void check_output(pixel_out_t o);
		pixel_out_t e;
		if (expected_pixels.size() == 0) begin
			$error("result word arrived with no expectation waiting");
			errors++;
			return;
		end
		e = expected_pixels.pop_front();
		for (int c = 0; c < 4; c++) begin
			if (o.pix[c] !== e.pix[c]) begin
				$error("%s expected %0d actual %0d", chan_name[c], e.pix[c], o.pix[c]);
				errors++;
			end
		end
		if (o.frame_end !== e.frame_end) begin
			$error("frame_end expected %0d actual %0d", e.frame_end, o.frame_end);
			errors++;
		end
	endfunction

	function void check_leftover();
		if (expected_pixels.size() != 0) begin
			$error("%0d expected words never arrived", expected_pixels.size());
			errors++;
		end
	endfunction
endclass

module tb_top;
	localparam int IDLE_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 20;
	localparam int PHASE_ITEMS = 280;

	logic                          clk;
	logic                          arst_n;
	logic                          in_valid;
	logic                          in_stall;
	logic [1:0]                    op;
	logic [7:0]                    src_red;
	logic [7:0]                    src_green;
	logic [7:0]                    src_blue;
	logic [7:0]                    src_alpha;
	logic [7:0]                    dst_red;
	logic [7:0]                    dst_green;
	logic [7:0]                    dst_blue;
	logic [7:0]                    dst_alpha;
	logic                          last_in_frame;
	logic                          out_valid;
	logic                          out_stall;
	logic [7:0]                    out_red;
	logic [7:0]                    out_green;
	logic [7:0]                    out_blue;
	logic [7:0]                    out_alpha;
	logic                          frame_end;
	logic                          cfg_write;
	logic [rpc_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [7:0]                    cfg_data;

	pixel_scoreboard sb;
	bit              idling_on;
	int              idle_cycles;
	int              stall_left;
	int              run_left;

	rgba_pixel_compositor u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.op            (op),
		.src_red       (src_red),
		.src_green     (src_green),
		.src_blue      (src_blue),
		.src_alpha     (src_alpha),
		.dst_red       (dst_red),
		.dst_green     (dst_green),
		.dst_blue      (dst_blue),
		.dst_alpha     (dst_alpha),
		.last_in_frame (last_in_frame),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.out_red       (out_red),
		.out_green     (out_green),
		.out_blue      (out_blue),
		.out_alpha     (out_alpha),
		.frame_end     (frame_end),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
	end

	always #1 clk = ~clk;

	function automatic pixel_in_t make_pixel(logic [1:0] o, int unsigned sr, int unsigned sg,
			int unsigned sbl, int unsigned sa, int unsigned dr, int unsigned dg,
			int unsigned dbl, int unsigned da, int unsigned l);
		pixel_in_t p;
		p.op = o;
		p.src = {8'(sa), 8'(sbl), 8'(sg), 8'(sr)};
		p.dst = {8'(da), 8'(dbl), 8'(dg), 8'(dr)};
		p.last = 1'(l);
		return p;
	endfunction

	// Channel values lean toward the ends of the range.
	function automatic logic [7:0] random_channel();
		case ($urandom_range(0, 7))
			0: return 8'd0;
			1: return 8'd255;
			2: return 8'd1;
			3: return 8'd254;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic pixel_in_t random_pixel();
		pixel_in_t   p;
		int unsigned pick;
		pick = $urandom_range(0, 15);
		if (pick < 5) p.op = rpc_pkg::OP_COPY;
		else if (pick < 11) p.op = rpc_pkg::OP_BLEND;
		else if (pick < 15) p.op = rpc_pkg::OP_FLATTEN;
		else p.op = rpc_pkg::OP_NONE;
		for (int c = 0; c < 4; c++) begin
			p.src[c] = random_channel();
			p.dst[c] = random_channel();
		end
		p.last = ($urandom_range(0, 15) == 0);
		return p;
	endfunction

	// Called at a falling edge; returns at the falling edge after the word is taken.
	task automatic send_pixel(pixel_in_t p);
		if (idling_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(negedge clk);
		end
		op <= p.op;
		src_red <= p.src[0];
		src_green <= p.src[1];
		src_blue <= p.src[2];
		src_alpha <= p.src[3];
		dst_red <= p.dst[0];
		dst_green <= p.dst[1];
		dst_blue <= p.dst[2];
		dst_alpha <= p.dst[3];
		last_in_frame <= p.last;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		sb.note_input(p);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (sb.expected_pixels.size() != 0) @(negedge clk);
	endtask

	task automatic write_reg(logic [rpc_pkg::CFG_IDX_W-1:0] idx, logic [7:0] val);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
	endtask

	// Only used while nothing is in flight.
	task automatic set_background(int unsigned r, int unsigned g, int unsigned b);
		logic [2:0][7:0] colour;
		colour = {8'(b), 8'(g), 8'(r)};
		write_reg(rpc_pkg::CFG_BG_RED, colour[0]);
		write_reg(rpc_pkg::CFG_BG_GREEN, colour[1]);
		write_reg(rpc_pkg::CFG_BG_BLUE, colour[2]);
		cfg_write <= 1'b0;
		sb.background = colour;
		@(negedge clk);
	endtask

	// The receiver alternates stall bursts with free-running stretches.
	always @(negedge clk) begin
		if (!idling_on) begin
			stall_left = 0;
			run_left = 0;
			out_stall <= 1'b0;
		end else begin
			if (stall_left == 0 && run_left == 0) begin
				if ($urandom_range(0, 2) == 0) stall_left = $urandom_range(1, 10);
				else run_left = $urandom_range(1, 30);
			end
			if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else begin
				run_left--;
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			sb.check_output({{out_alpha, out_blue, out_green, out_red}, frame_end});
		end
	end

	initial begin
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
			else idle_cycles++;
		end
		$display("FAIL rgba_pixel_compositor");
		$finish;
	end

	initial begin
		sb = new();
		idling_on = 1'b1;
		arst_n = 1'b0;
		in_valid = 1'b0;
		out_stall = 1'b0;
		op = rpc_pkg::OP_COPY;
		src_red = '0;
		src_green = '0;
		src_blue = '0;
		src_alpha = '0;
		dst_red = '0;
		dst_green = '0;
		dst_blue = '0;
		dst_alpha = '0;
		last_in_frame = 1'b0;
		cfg_write = 1'b0;
		cfg_index = rpc_pkg::CFG_BG_RED;
		cfg_data = '0;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed words against the reset background of black.
		send_pixel(make_pixel(rpc_pkg::OP_COPY, 0, 0, 0, 0, 255, 255, 255, 255, 0));
		send_pixel(make_pixel(rpc_pkg::OP_COPY, 255, 255, 255, 255, 0, 0, 0, 0, 1));
		send_pixel(make_pixel(rpc_pkg::OP_NONE, 12, 200, 99, 77, 255, 0, 170, 85, 1));
		send_pixel(make_pixel(rpc_pkg::OP_NONE, 255, 255, 255, 255, 0, 0, 0, 0, 0));
		send_pixel(make_pixel(rpc_pkg::OP_BLEND, 10, 20, 30, 255, 200, 100, 50, 0, 0));
		send_pixel(make_pixel(rpc_pkg::OP_BLEND, 10, 20, 30, 0, 200, 100, 50, 99, 1));
		send_pixel(make_pixel(rpc_pkg::OP_BLEND, 255, 128, 0, 1, 0, 64, 255, 0, 0));
		send_pixel(make_pixel(rpc_pkg::OP_BLEND, 255, 255, 255, 1, 0, 0, 0, 255, 0));
		send_pixel(make_pixel(rpc_pkg::OP_BLEND, 0, 0, 0, 254, 255, 255, 255, 255, 0));
		send_pixel(make_pixel(rpc_pkg::OP_BLEND, 255, 0, 255, 128, 0, 255, 0, 128, 1));
		send_pixel(make_pixel(rpc_pkg::OP_BLEND, 255, 255, 255, 200, 255, 255, 255, 0, 0));
		send_pixel(make_pixel(rpc_pkg::OP_BLEND, 255, 255, 255, 254, 255, 255, 255, 255, 0));
		send_pixel(make_pixel(rpc_pkg::OP_FLATTEN, 200, 100, 50, 0, 1, 2, 3, 4, 0));
		send_pixel(make_pixel(rpc_pkg::OP_FLATTEN, 200, 100, 50, 255, 1, 2, 3, 4, 1));
		send_pixel(make_pixel(rpc_pkg::OP_FLATTEN, 255, 255, 255, 128, 0, 0, 0, 0, 0));
		send_pixel(make_pixel(rpc_pkg::OP_FLATTEN, 255, 255, 255, 1, 0, 0, 0, 0, 0));
		wait_drained();

		// Flatten against white, then a run of random words per background.
		set_background(255, 255, 255);
		send_pixel(make_pixel(rpc_pkg::OP_FLATTEN, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		send_pixel(make_pixel(rpc_pkg::OP_FLATTEN, 0, 0, 0, 128, 0, 0, 0, 0, 1));
		send_pixel(make_pixel(rpc_pkg::OP_FLATTEN, 0, 0, 0, 254, 0, 0, 0, 0, 0));

		for (int phase = 0; phase < 5; phase++) begin
			if (phase > 0) begin
				wait_drained();
				case (phase)
					2: set_background(0, 0, 0);
					3: set_background(255, 0, 255);
					default: set_background($urandom_range(0, 255),
						$urandom_range(0, 255), $urandom_range(0, 255));
				endcase
			end
			// The last phase runs at full rate on both sides.
			if (phase == 4) idling_on = 1'b0;
			for (int n = 0; n < PHASE_ITEMS; n++) send_pixel(random_pixel());
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(negedge clk);
		sb.check_leftover();
		if (sb.errors == 0) begin
			$display("PASS rgba_pixel_compositor");
		end else begin
			$display("FAIL rgba_pixel_compositor");
		end
		$finish;
	end
endmodule
